>>> rtl/core/priority_ready_queue_assert.svh
// Assertion macros for the ready queue checker.
// Each expects clk and arst_n in scope.
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define PRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/prq_pkg.sv
package prq_pkg;

	// Field widths of the command and response beats
	localparam int FUNC_W = 2;
	localparam int PID_W  = 16;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Parameter defaults
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF    = 16;
	localparam int PRIO_BITS_DEF   = 8;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_SORTED = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TAIL   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PID_W-1:0]  pid;
		logic [PRIO_W-1:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic [PID_W-1:0]  out_pid;
		logic [PRIO_W-1:0] out_priority;
		logic              pop_valid;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_LAST
	} state_t;

endpackage

>>> rtl/core/prq_ram.sv
module prq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/prq_rank.sv
module prq_rank #(
	parameter int PID_BITS  = 16,
	parameter int PRIO_BITS = 8
) (
	input  logic [PRIO_BITS+PID_BITS-1:0] cand,
	input  logic [PRIO_BITS+PID_BITS-1:0] held,
	output logic                          wins
);

	logic [PRIO_BITS-1:0] cand_prio;
	logic [PRIO_BITS-1:0] held_prio;
	logic [PID_BITS-1:0]  cand_pid;
	logic [PID_BITS-1:0]  held_pid;

	assign cand_prio = cand[PRIO_BITS+PID_BITS-1:PID_BITS];
	assign held_prio = held[PRIO_BITS+PID_BITS-1:PID_BITS];
	assign cand_pid  = cand[PID_BITS-1:0];
	assign held_pid  = held[PID_BITS-1:0];

	// Higher priority first, higher pid breaks a tie
	assign wins = (cand_prio > held_prio) ||
		((cand_prio == held_prio) && (cand_pid > held_pid));

endmodule

>>> rtl/core/priority_ready_queue.sv
// Channel   Handshake                 Payload
// command   start in, busy out        cmd (func, pid, priority_req)
// response  done out, one cycle wide  rsp (out_pid, out_priority, pop_valid, status, occupancy)
//
// Tail push, full push, empty pop and the unused code: result in the cycle after start.
// Pop: the queue memory read is registered, then S_POP returns the head.
// Sorted push: one compare/shift step per held entry in S_SCAN, then S_LAST;
// the steps run in series on the single memory port pair and the shared rank comparator.
// busy is high while a pop or a walk runs; reset empties the queue, memory is not cleared.
// done cannot be held off: done is high for one cycle only; rsp holds until the next command.
module priority_ready_queue #(
	parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = prq_pkg::PID_BITS_DEF,
	parameter int PRIO_BITS   = prq_pkg::PRIO_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  prq_pkg::cmd_t cmd,
	output logic          done,
	output prq_pkg::rsp_t rsp
);

	import prq_pkg::*;

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int EW    = PRIO_BITS + PID_BITS;

	state_t           state_q, state_d;
	logic [AW-1:0]    head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] idx_nx;
	logic             placed_q, placed_d;
	logic [EW-1:0]    carry_q, carry_d;
	logic             done_q, done_d;
	rsp_t             rsp_q, rsp_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [EW-1:0]    ram_rdata;
	logic             wins;
	logic [EW-1:0]    new_entry;
	logic             full;
	logic             empty;

	// Map a place in the queue onto a memory address past the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [CNT_W-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, head} + (AW+1)'(pos);
		if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (AW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	prq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	prq_rank #(
		.PID_BITS  (PID_BITS),
		.PRIO_BITS (PRIO_BITS)
	) u_rank (
		.cand (carry_q),
		.held (ram_rdata),
		.wins (wins)
	);

	assign new_entry = {PRIO_BITS'(cmd.priority_req), PID_BITS'(cmd.pid)};
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign idx_nx    = idx_q + 1'b1;

	// Hold state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			placed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			placed_q <= placed_d;
			done_q   <= done_d;
		end
	end

	// Carried entry and response beat
	always_ff @(posedge clk) begin
		carry_q <= carry_d;
		rsp_q   <= rsp_d;
	end

	// Sequence the operation
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		placed_d  = placed_q;
		carry_d   = carry_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, count_q);
		ram_wdata = carry_q;
		ram_raddr = head_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					rsp_d.out_pid      = '0;
					rsp_d.out_priority = '0;
					rsp_d.pop_valid    = 1'b0;
					rsp_d.status       = ST_OK;
					rsp_d.occupancy    = OCC_W'(count_q);
					case (cmd.func)
						FUNC_SORTED, FUNC_TAIL: begin
							if (full) begin
								rsp_d.status = ST_FULL;
								done_d       = 1'b1;
							end else if (cmd.func == FUNC_TAIL || empty) begin
								// append at the tail in one step
								ram_we          = 1'b1;
								ram_wdata       = new_entry;
								count_d         = count_q + 1'b1;
								rsp_d.occupancy = OCC_W'(count_q + 1'b1);
								done_d          = 1'b1;
							end else begin
								// start the walk, read the head
								carry_d  = new_entry;
								placed_d = 1'b0;
								idx_d    = '0;
								state_d  = S_SCAN;
							end
						end
						FUNC_POP: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
								done_d       = 1'b1;
							end else begin
								state_d = S_POP;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				// return the head and advance it
				rsp_d.out_pid      = PID_W'(ram_rdata[PID_BITS-1:0]);
				rsp_d.out_priority = PRIO_W'(ram_rdata[EW-1:PID_BITS]);
				rsp_d.pop_valid    = 1'b1;
				rsp_d.status       = ST_OK;
				rsp_d.occupancy    = OCC_W'(count_q - 1'b1);
				head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_d = count_q - 1'b1;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				// read ahead while the current entry is ranked or shifted
				ram_raddr = phys(head_q, idx_nx);
				ram_waddr = phys(head_q, idx_q);
				if (placed_q || wins) begin
					ram_we   = 1'b1;
					carry_d  = ram_rdata;
					placed_d = 1'b1;
				end
				idx_d = idx_nx;
				if (idx_nx == count_q) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				// drop the carried entry at the tail
				ram_we             = 1'b1;
				count_d            = count_q + 1'b1;
				rsp_d.out_pid      = '0;
				rsp_d.out_priority = '0;
				rsp_d.pop_valid    = 1'b0;
				rsp_d.status       = ST_OK;
				rsp_d.occupancy    = OCC_W'(count_q + 1'b1);
				done_d             = 1'b1;
				state_d            = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> rtl/core/prq_checker.sv
`include "priority_ready_queue_assert.svh"

module prq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input prq_pkg::cmd_t cmd,
	input logic          done,
	input prq_pkg::rsp_t rsp
);

	import prq_pkg::*;

	// A returned entry always carries an ok status
	`PRQ_ASSERT_NOW(a_pop_ok, done && rsp.pop_valid, rsp.status == ST_OK, "pop beat with bad status")

	// An empty pop reports an empty queue and no entry
	`PRQ_ASSERT_NOW(a_empty_pop, done && rsp.status == ST_EMPTY, rsp.occupancy == '0 && !rsp.pop_valid, "empty pop beat inconsistent")

	// A beat without an entry has zero payload
	`PRQ_ASSERT_NOW(a_zero_fields, done && !rsp.pop_valid, rsp.out_pid == '0 && rsp.out_priority == '0, "payload set without entry")

	// A tail push answers in the next cycle
	`PRQ_ASSERT_NEXT(a_tail_fast, start && !busy && cmd.func == FUNC_TAIL, done && !busy, "tail push not answered at once")

	// No beat appears out of an idle cycle
	`PRQ_ASSERT_NEXT(a_no_stray, !busy && !start, !done, "response beat with no command")

endmodule

bind priority_ready_queue prq_checker u_prq_checker (.*);
